// ===== rtl/b64e_pkg.sv =====
// Shared types, constants and the sextet-to-ASCII map for the Base64 encoder.
// No dependencies.
package b64e_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } out_item_t;

    // One symbol of a job: pad flag over a 6-bit sextet
    typedef struct packed {
        logic       pad;
        logic [5:0] sextet;
    } sym_t;

    // Work handed from front to back: up to four symbols
    typedef struct packed {
        sym_t [3:0] sym;
        logic [1:0] last_idx;
        logic       last_flag;
    } job_t;

    typedef struct packed {
        logic [1:0] phase;
    } front_status_t;

    localparam logic [1:0] PHASE_START  = 2'd0;
    localparam logic [1:0] PHASE_SECOND = 2'd1;
    localparam logic [1:0] PHASE_THIRD  = 2'd2;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)
            c = 8'h41 + {2'b00, v};
        else if (v < 6'd52)
            c = 8'h61 + {2'b00, v} - 8'd26;
        else if (v < 6'd62)
            c = 8'h30 + {2'b00, v} - 8'd52;
        else if (v == 6'd62)
            c = 8'h2B;
        else
            c = 8'h2F;
        return c;
    endfunction

endpackage

// ===== rtl/b64e_front.sv =====
// Front end: accepts bytes, tracks group phase and leftover bits, builds jobs.
// Depends on b64e_pkg.
module b64e_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  b64e_pkg::in_item_t      in_data,
    input  logic                    q_full,
    output logic                    q_push,
    output b64e_pkg::job_t          q_job,
    output b64e_pkg::front_status_t status
);

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [3:0] left_reg;
    logic [3:0] left_next;
    logic [7:0] b;
    logic       fin;

    assign in_stall     = q_full;
    assign q_push       = in_valid && !q_full;
    assign status.phase = phase_reg;
    assign b            = in_data.data_byte;
    assign fin          = in_data.final_byte;

    always_comb
    begin
        q_job           = '0;
        q_job.last_flag = fin;
        phase_next      = phase_reg;
        left_next       = left_reg;
        case (phase_reg)
            b64e_pkg::PHASE_SECOND:
            begin
                q_job.sym[0].sextet = {left_reg[1:0], b[7:4]};
                if (fin)
                begin
                    q_job.sym[1].sextet = {b[3:0], 2'b00};
                    q_job.sym[2].pad    = 1'b1;
                    q_job.last_idx      = 2'd2;
                    phase_next          = b64e_pkg::PHASE_START;
                    left_next           = 4'd0;
                end
                else
                begin
                    q_job.last_idx = 2'd0;
                    phase_next     = b64e_pkg::PHASE_THIRD;
                    left_next      = b[3:0];
                end
            end
            b64e_pkg::PHASE_THIRD:
            begin
                q_job.sym[0].sextet = {left_reg, b[7:6]};
                q_job.sym[1].sextet = b[5:0];
                q_job.last_idx      = 2'd1;
                phase_next          = b64e_pkg::PHASE_START;
                left_next           = 4'd0;
            end
            default:
            begin
                // start of group; the unused code behaves the same
                q_job.sym[0].sextet = b[7:2];
                if (fin)
                begin
                    q_job.sym[1].sextet = {b[1:0], 4'b0000};
                    q_job.sym[2].pad    = 1'b1;
                    q_job.sym[3].pad    = 1'b1;
                    q_job.last_idx      = 2'd3;
                    phase_next          = b64e_pkg::PHASE_START;
                    left_next           = 4'd0;
                end
                else
                begin
                    q_job.last_idx = 2'd0;
                    phase_next     = b64e_pkg::PHASE_SECOND;
                    left_next      = {2'b00, b[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= b64e_pkg::PHASE_START;
            left_reg  <= 4'd0;
        end
        else if (q_push)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule

// ===== rtl/b64e_queue.sv =====
// Small FIFO of jobs between front and back.
// Depends on b64e_pkg.
module b64e_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  b64e_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output b64e_pkg::job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    b64e_pkg::job_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == FULL_CNT);
    assign valid    = (count_reg != '0);
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== rtl/b64e_back.sv =====
// Back end: takes jobs from the queue, emits one character per cycle while out_stall is low.
// Depends on b64e_pkg.
module b64e_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  b64e_pkg::job_t      q_job,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_stall,
    output b64e_pkg::out_item_t out_data
);

    b64e_pkg::job_t      job_reg;
    logic                busy_reg;
    logic [1:0]          idx_reg;
    logic                out_valid_reg;
    b64e_pkg::out_item_t out_data_reg;
    b64e_pkg::sym_t      cur_sym;
    logic                load;
    logic                emit;
    logic                done;

    assign load      = !out_valid_reg || !out_stall;
    assign emit      = busy_reg && load;
    assign done      = emit && (idx_reg == job_reg.last_idx);
    assign q_pop     = q_valid && (!busy_reg || done);
    assign cur_sym   = job_reg.sym[idx_reg];
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                out_valid_reg <= emit;
            if (q_pop)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= 2'd0;
            end
            else if (done)
            begin
                busy_reg <= 1'b0;
            end
            else if (emit)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            job_reg <= q_job;
        if (emit)
        begin
            out_data_reg.char_code <= cur_sym.pad ? b64e_pkg::PAD_CHAR
                                                  : b64e_pkg::sextet_char(cur_sym.sextet);
            out_data_reg.last_char <= job_reg.last_flag && (idx_reg == job_reg.last_idx);
        end
    end

endmodule

// ===== rtl/base64_stream_encoder_core.sv =====
// Base64 stream encoder: byte in, one ASCII character per output transaction.
// Path: a byte's job is written to the queue, then into the back end's job register,
// and its characters leave from the back end's single output register, one per cycle
// while out_stall is low; a byte yields 1, 2, 3 or 4 characters, about 4/3 on average.
// Reset: rst_n async low clears group phase, leftover bits, queue and output valid.
// Depends on b64e_pkg, b64e_front, b64e_queue, b64e_back.
module base64_stream_encoder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  b64e_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output b64e_pkg::out_item_t out_data
);

    logic                    q_push;
    logic                    q_full;
    logic                    q_pop;
    logic                    q_valid;
    b64e_pkg::job_t          push_job;
    b64e_pkg::job_t          head_job;
    b64e_pkg::front_status_t front_status;

    b64e_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job),
        .status   (front_status)
    );

    b64e_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .head_job (head_job)
    );

    b64e_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_job     (head_job),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef SYNTH
    a_final_resets_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.final_byte)
        |=> (front_status.phase == b64e_pkg::PHASE_START))
        else $error("group phase not cleared after final byte");

    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("job popped from empty queue");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job pushed into full queue");

    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (front_status.phase == b64e_pkg::PHASE_START)
        || (front_status.phase == b64e_pkg::PHASE_SECOND)
        || (front_status.phase == b64e_pkg::PHASE_THIRD))
        else $error("group phase reached unused code");
`endif

endmodule

// ===== tb/sv/base64_stream_encoder_core_tb.sv =====
// Self-checking testbench for base64_stream_encoder_core: drives byte streams,
// predicts the Base64 character stream and checks every output transaction.
// Depends on b64e_pkg and the base64_stream_encoder_core RTL.
`timescale 1ns / 100ps

module base64_stream_encoder_core_tb;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLDOFF_CYCLES = 200;
    localparam int TAIL_CYCLES   = 20;
    localparam int RANDOM_BYTES  = 480;

    typedef struct {
        b64e_pkg::in_item_t item;
        bit       drain_first;   // wait for the output side to empty before offering
    } byte_slot_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    b64e_pkg::in_item_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    b64e_pkg::out_item_t out_data;

    byte_slot_t pending_bytes[$];
    b64e_pkg::out_item_t  expected_chars[$];

    string b64_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // encoder state as predicted by the testbench
    logic [1:0] enc_phase = b64e_pkg::PHASE_START;
    logic [3:0] enc_rem = '0;

    int  bytes_total = 0;
    int  messages_total = 0;
    int  bytes_sent = 0;
    int  chars_checked = 0;
    int  pads_checked = 0;
    int  fail_count = 0;
    int  cycle_count = 0;
    int  holdoff_left = 0;
    bit  holdoff_req = 1'b0;
    bit  holdoff_done = 1'b0;
    bit  idle_en = 1'b1;

    base64_stream_encoder_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [7:0] sextet_to_ascii(input logic [5:0] v);
        return b64_alphabet[v];
    endfunction

    function automatic void expect_char(input logic [7:0] code, input logic last);
        b64e_pkg::out_item_t e;
        e.char_code = code;
        e.last_char = last;
        expected_chars.push_back(e);
    endfunction

    // Characters caused by one accepted byte; updates the group phase and leftover bits.
    function automatic void predict_chars(input b64e_pkg::in_item_t b);
        logic [7:0] d;
        logic       fin;
        d = b.data_byte;
        fin = b.final_byte;
        case (enc_phase)
            b64e_pkg::PHASE_SECOND:
            begin
                expect_char(sextet_to_ascii({enc_rem[1:0], d[7:4]}), 1'b0);
                if (fin)
                begin
                    expect_char(sextet_to_ascii({d[3:0], 2'b00}), 1'b0);
                    expect_char(b64e_pkg::PAD_CHAR, 1'b1);
                    enc_phase = b64e_pkg::PHASE_START;
                    enc_rem = '0;
                end
                else
                begin
                    enc_rem = d[3:0];
                    enc_phase = b64e_pkg::PHASE_THIRD;
                end
            end
            b64e_pkg::PHASE_THIRD:
            begin
                expect_char(sextet_to_ascii({enc_rem, d[7:6]}), 1'b0);
                expect_char(sextet_to_ascii(d[5:0]), fin);
                enc_phase = b64e_pkg::PHASE_START;
                enc_rem = '0;
            end
            default:
            begin
                expect_char(sextet_to_ascii(d[7:2]), 1'b0);
                if (fin)
                begin
                    expect_char(sextet_to_ascii({d[1:0], 4'b0000}), 1'b0);
                    expect_char(b64e_pkg::PAD_CHAR, 1'b0);
                    expect_char(b64e_pkg::PAD_CHAR, 1'b1);
                    enc_phase = b64e_pkg::PHASE_START;
                    enc_rem = '0;
                end
                else
                begin
                    enc_rem = {2'b00, d[1:0]};
                    enc_phase = b64e_pkg::PHASE_SECOND;
                end
            end
        endcase
    endfunction

    function automatic void add_byte(input logic [7:0] d, input logic fin, input bit drain);
        byte_slot_t s;
        s.item.data_byte = d;
        s.item.final_byte = fin;
        s.drain_first = drain;
        pending_bytes.push_back(s);
        bytes_total++;
        if (fin)
            messages_total++;
    endfunction

    // Sender: holds a stalled transaction, otherwise offers the next byte or idles.
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic offer;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_chars(in_data);
                bytes_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                offer = pending_bytes.size() != 0 && !(idle_en && $urandom_range(99) < 18);
                if (offer && pending_bytes[0].drain_first && expected_chars.size() != 0)
                    offer = 1'b0;
                if (offer)
                begin
                    in_data <= pending_bytes[0].item;
                    void'(pending_bytes.pop_front());
                end
                in_valid <= offer;
            end
        end
    end

    // Receiver: checks each accepted character, applies random stalls and the long hold-off.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        b64e_pkg::out_item_t e;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected character: char_code %02h last_char %0b",
                           out_data.char_code, out_data.last_char);
                    fail_count++;
                end
                else
                begin
                    e = expected_chars.pop_front();
                    if (out_data.char_code !== e.char_code)
                    begin
                        $error("char_code mismatch: expected %02h actual %02h",
                               e.char_code, out_data.char_code);
                        fail_count++;
                    end
                    if (out_data.last_char !== e.last_char)
                    begin
                        $error("last_char mismatch: expected %0b actual %0b",
                               e.last_char, out_data.last_char);
                        fail_count++;
                    end
                    chars_checked++;
                    if (e.char_code == b64e_pkg::PAD_CHAR)
                        pads_checked++;
                end
            end
            if (holdoff_req && !holdoff_done)
            begin
                holdoff_left = HOLDOFF_CYCLES;
                holdoff_done = 1'b1;
            end
            if (holdoff_left != 0)
            begin
                holdoff_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= idle_en && $urandom_range(99) < 18;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes sent, %0d characters pending",
                     cycle_count, bytes_sent, expected_chars.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        int len;
        int n;
        logic [7:0] d;

        // directed: one, two and three byte messages cover every padding case
        add_byte(8'h00, 1'b1, 1'b0);
        add_byte(8'hFF, 1'b1, 1'b0);
        add_byte(8'h4D, 1'b0, 1'b0);
        add_byte(8'h61, 1'b1, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b1, 1'b0);
        add_byte(8'h4D, 1'b0, 1'b0);
        add_byte(8'h61, 1'b0, 1'b0);
        add_byte(8'h6E, 1'b1, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(8'h00, 1'b1, 1'b0);
        // '+' in sextet positions 0 and 3, '/' in positions 1, 2 and 3
        add_byte(8'hFB, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b1, 1'b0);
        add_byte(8'h14, 1'b0, 1'b0);
        add_byte(8'hFB, 1'b0, 1'b0);
        add_byte(8'h9C, 1'b0, 1'b0);
        add_byte(8'h03, 1'b0, 1'b0);
        add_byte(8'hD9, 1'b0, 1'b0);
        add_byte(8'h7E, 1'b1, 1'b0);

        n = 0;
        while (n < RANDOM_BYTES)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 9);
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(7))
                    0: d = 8'h00;
                    1: d = 8'hFF;
                    default: d = 8'($urandom_range(255));
                endcase
                add_byte(d, i == len - 1, n == 0 || n == 300);
                n++;
            end
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // receiver holds off while the sender keeps offering
        while (bytes_sent < 100)
            @(posedge clk);
        @(negedge clk);
        holdoff_req = 1'b1;

        while (bytes_sent < 200)
            @(posedge clk);
        @(negedge clk);
        idle_en = 1'b0;
        while (bytes_sent < 280)
            @(posedge clk);
        @(negedge clk);
        idle_en = 1'b1;

        while (bytes_sent < bytes_total)
            @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("encoded %0d bytes in %0d messages into %0d characters (%0d pads)",
                 bytes_sent, messages_total, chars_checked, pads_checked);
        $display("random stalls on both sides, one %0d-cycle output hold-off, %0d cycles",
                 HOLDOFF_CYCLES, cycle_count);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
